// ----- src/kfli_pkg.sv -----
`timescale 1ns / 1ps

package kfli_pkg;

	// Table geometry
	localparam int MAX_KEYFRAMES = 512;
	localparam int ADDR_W        = $clog2(MAX_KEYFRAMES);
	localparam int FC_W          = 10;
	localparam int NCH           = 5;
	localparam int ANGLE_W       = 10;
	localparam int ENTRY_W       = NCH * ANGLE_W;

	// Fixed-point pose and step count
	localparam int POSE_W        = 32;
	localparam int FRAC_W        = 16;
	localparam int STEPS_W       = 10;
	localparam int STEPS_RESET   = 100;

	// Serial arithmetic
	localparam int DVD_W         = ANGLE_W + FRAC_W;
	localparam int DIV_CYCLES    = DVD_W;
	localparam int DIGIT_W       = 4;
	localparam int ADD_CYCLES    = POSE_W / DIGIT_W;
	localparam int CNT_W         = $clog2(DIV_CYCLES);

	typedef enum logic [1:0] {
		ACT_SAVE = 2'd0,
		ACT_PLAY = 2'd1,
		ACT_TICK = 2'd2
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDA,
		ST_RDB,
		ST_LDB,
		ST_DIV,
		ST_LDINC,
		ST_ADD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_pose;
		logic load_inc;
		logic add_en;
		logic add_first;
	} pose_ctl_t;

	typedef struct packed {
		logic start;
		logic step;
	} div_ctl_t;

endpackage

// ----- src/kfli_store.sv -----
`timescale 1ns / 1ps

module kfli_store
	import kfli_pkg::*;
(
	input  logic               clk,
	input  logic               we,
	input  logic               re,
	input  logic [ADDR_W-1:0]  addr,
	input  logic [ENTRY_W-1:0] wdata,
	output logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem_q [MAX_KEYFRAMES];

	// Write one keyframe
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ----- src/kfli_div.sv -----
`timescale 1ns / 1ps

module kfli_div
	import kfli_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  div_ctl_t                 ctl,
	input  logic signed [ANGLE_W:0]  diff,
	input  logic [STEPS_W-1:0]       divisor,
	output logic [POSE_W-1:0]        quotient
);

	logic               neg_q;
	logic               zero_q;
	logic [STEPS_W-1:0] rem_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [ANGLE_W:0]   mag;
	logic [STEPS_W:0]   trial;
	logic               fits;
	logic [POSE_W-1:0]  qmag;

	// Magnitude of the frame difference
	assign mag   = diff[ANGLE_W] ? (~diff + 1'b1) : diff;
	// Bring down one dividend bit beside the partial remainder
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = (trial >= {1'b0, divisor});

	// Restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q  <= 1'b0;
			zero_q <= 1'b1;
		end else if (ctl.start) begin
			neg_q  <= diff[ANGLE_W];
			zero_q <= (divisor == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dvd_q <= {mag[ANGLE_W-1:0], {FRAC_W{1'b0}}};
		end else if (ctl.step) begin
			rem_q <= fits ? STEPS_W'(trial - {1'b0, divisor}) : trial[STEPS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	// Apply the sign, truncating toward zero
	assign qmag     = {{(POSE_W-DVD_W){1'b0}}, dvd_q};
	assign quotient = zero_q ? '0 : (neg_q ? (~qmag + 1'b1) : qmag);

endmodule

// ----- src/kfli_pose.sv -----
`timescale 1ns / 1ps

module kfli_pose
	import kfli_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  pose_ctl_t           ctl,
	input  logic [ANGLE_W-1:0]  angle,
	input  logic [POSE_W-1:0]   inc_in,
	output logic [POSE_W-1:0]   pose
);

	logic [POSE_W-1:0]  pose_q;
	logic [POSE_W-1:0]  inc_q;
	logic               carry_q;
	logic               cin;
	logic [DIGIT_W:0]   dsum;

	// One digit of the sum, carry cleared on the first digit
	assign cin  = ctl.add_first ? 1'b0 : carry_q;
	assign dsum = {1'b0, pose_q[DIGIT_W-1:0]} + {1'b0, inc_q[DIGIT_W-1:0]}
		+ {{DIGIT_W{1'b0}}, cin};

	// Rotate pose and increment a digit at a time; both realign after a full pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_q  <= '0;
			inc_q   <= '0;
			carry_q <= 1'b0;
		end else begin
			if (ctl.load_pose) begin
				pose_q <= {{(POSE_W-ANGLE_W-FRAC_W){angle[ANGLE_W-1]}}, angle,
					{FRAC_W{1'b0}}};
			end else if (ctl.add_en) begin
				pose_q <= {dsum[DIGIT_W-1:0], pose_q[POSE_W-1:DIGIT_W]};
			end
			if (ctl.load_inc) begin
				inc_q <= inc_in;
			end else if (ctl.add_en) begin
				inc_q <= {inc_q[DIGIT_W-1:0], inc_q[POSE_W-1:DIGIT_W]};
			end
			if (ctl.add_en) begin
				carry_q <= dsum[DIGIT_W];
			end
		end
	end

	assign pose = pose_q;

endmodule

// ----- src/keyframe_linear_interpolator.sv -----
`timescale 1ns / 1ps

// Five-channel keyframe player. Each accepted beat gives exactly one result beat
// with the pose (signed 16.16), the playing flag, the stored frame count and the
// save rejection flag. One item is worked on at a time, and a new beat is taken only
// once the previous result has moved into the result register. A save, a stop, an
// ignored code or a tick while stopped passes only through the execute and done
// states. An interpolating tick runs the pose adders, which work 4 bits a cycle
// over 32-bit poses. Starting playback or moving to the next segment reads the
// single-port keyframe table twice and then runs the bit-serial dividers, one per
// channel, that form the segment increments. A stalled result register holds the
// block in its done state. The table needs no clearing after reset.
// steps_per_segment is written through cfg_we/cfg_data and resets to 100.
module keyframe_linear_interpolator
	import kfli_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [STEPS_W-1:0]  cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [ANGLE_W-1:0]  thumb_angle,
	input  logic [ANGLE_W-1:0]  index_angle,
	input  logic [ANGLE_W-1:0]  middle_angle,
	input  logic [ANGLE_W-1:0]  ring_angle,
	input  logic [ANGLE_W-1:0]  little_angle,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [POSE_W-1:0]   pose_thumb,
	output logic [POSE_W-1:0]   pose_index,
	output logic [POSE_W-1:0]   pose_middle,
	output logic [POSE_W-1:0]   pose_ring,
	output logic [POSE_W-1:0]   pose_little,
	output logic                is_playing,
	output logic [FC_W-1:0]     stored_frames,
	output logic                save_rejected
);

	state_t             state_q, state_d;
	logic [1:0]         act_q;
	logic [ENTRY_W-1:0] angles_q;
	logic [ENTRY_W-1:0] frame_a_q;
	logic [FC_W-1:0]    frame_count_q;
	logic               playing_q;
	logic [ADDR_W-1:0]  segment_q;
	logic [STEPS_W-1:0] step_q;
	logic [STEPS_W-1:0] steps_q;
	logic               rej_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               out_valid_q;
	logic [POSE_W-1:0]  out_pose_q [NCH];
	logic               out_playing_q;
	logic [FC_W-1:0]    out_count_q;
	logic               out_rej_q;

	logic               table_free;
	logic               can_play;
	logic               seg_due;
	logic               last_seg;
	logic               out_free;

	logic               mem_we;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_addr;
	logic [ENTRY_W-1:0] mem_rdata;

	pose_ctl_t          pose_ctl;
	div_ctl_t           div_ctl;
	logic [POSE_W-1:0]  pose_val [NCH];
	logic [POSE_W-1:0]  inc_val  [NCH];

	// Decisions on the current state
	assign table_free = (frame_count_q < FC_W'(MAX_KEYFRAMES));
	assign can_play   = !playing_q && (frame_count_q > FC_W'(1));
	assign seg_due    = (step_q >= steps_q);
	assign last_seg   = (({2'b00, segment_q} + (ADDR_W+2)'(3)) > {1'b0, frame_count_q});
	assign out_free   = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (act_q)
					ACT_PLAY: state_d = can_play ? ST_RDA : ST_DONE;
					ACT_TICK: begin
						if (!playing_q) begin
							state_d = ST_DONE;
						end else if (!seg_due) begin
							state_d = ST_ADD;
						end else begin
							state_d = last_seg ? ST_DONE : ST_RDA;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_RDA:   state_d = ST_RDB;
			ST_RDB:   state_d = ST_LDB;
			ST_LDB:   state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_CYCLES-1)) begin
					state_d = ST_LDINC;
				end
			end
			ST_LDINC: state_d = ST_DONE;
			ST_ADD: begin
				if (cnt_q == CNT_W'(ADD_CYCLES-1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs of each state
	always_comb begin
		in_ready           = 1'b0;
		mem_we             = 1'b0;
		mem_re             = 1'b0;
		mem_addr           = frame_count_q[ADDR_W-1:0];
		pose_ctl           = '0;
		div_ctl            = '0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EXEC: mem_we = (act_q == ACT_SAVE) && table_free;
			ST_RDA: begin
				mem_re   = 1'b1;
				mem_addr = segment_q;
			end
			ST_RDB: begin
				mem_re             = 1'b1;
				mem_addr           = segment_q + ADDR_W'(1);
				pose_ctl.load_pose = (act_q == ACT_PLAY);
			end
			ST_LDB:   div_ctl.start     = 1'b1;
			ST_DIV:   div_ctl.step      = 1'b1;
			ST_LDINC: pose_ctl.load_inc = 1'b1;
			ST_ADD: begin
				pose_ctl.add_en    = 1'b1;
				pose_ctl.add_first = (cnt_q == '0);
			end
			default: ;
		endcase
	end

	// State and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			frame_count_q <= '0;
			playing_q     <= 1'b0;
			segment_q     <= '0;
			step_q        <= '0;
			steps_q       <= STEPS_W'(STEPS_RESET);
			rej_q         <= 1'b0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				steps_q <= cfg_data;
			end
			if (state_q == ST_IDLE && in_valid) begin
				rej_q <= 1'b0;
			end
			// Advance the serial counter, clear it on leaving a serial state
			if ((state_q == ST_DIV || state_q == ST_ADD) && state_d == state_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (state_q == ST_EXEC) begin
				case (act_q)
					ACT_SAVE: begin
						if (table_free) begin
							frame_count_q <= frame_count_q + FC_W'(1);
						end else begin
							rej_q <= 1'b1;
						end
					end
					ACT_PLAY: begin
						if (can_play) begin
							segment_q <= '0;
							step_q    <= '0;
							playing_q <= 1'b1;
						end else begin
							playing_q <= 1'b0;
						end
					end
					ACT_TICK: begin
						if (playing_q) begin
							if (!seg_due) begin
								step_q <= step_q + STEPS_W'(1);
							end else if (last_seg) begin
								segment_q <= '0;
								playing_q <= 1'b0;
							end else begin
								segment_q <= segment_q + ADDR_W'(1);
								step_q    <= '0;
							end
						end
					end
					default: ;
				endcase
			end
			// Result register: hold until taken
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			act_q    <= action;
			angles_q <= {little_angle, ring_angle, middle_angle, index_angle, thumb_angle};
		end
		if (state_q == ST_RDB) begin
			frame_a_q <= mem_rdata;
		end
		if (state_q == ST_DONE && out_free) begin
			for (int c = 0; c < NCH; c++) begin
				out_pose_q[c] <= pose_val[c];
			end
			out_playing_q <= playing_q;
			out_count_q   <= frame_count_q;
			out_rej_q     <= rej_q;
		end
	end

	kfli_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (angles_q),
		.rdata (mem_rdata)
	);

	// One divider and one pose accumulator per channel
	for (genvar c = 0; c < NCH; c++) begin : g_lane
		logic signed [ANGLE_W:0] diff;

		assign diff = $signed({mem_rdata[c*ANGLE_W+ANGLE_W-1], mem_rdata[c*ANGLE_W +: ANGLE_W]})
			- $signed({frame_a_q[c*ANGLE_W+ANGLE_W-1], frame_a_q[c*ANGLE_W +: ANGLE_W]});

		kfli_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (div_ctl),
			.diff     (diff),
			.divisor  (steps_q),
			.quotient (inc_val[c])
		);

		kfli_pose u_pose (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (pose_ctl),
			.angle  (mem_rdata[c*ANGLE_W +: ANGLE_W]),
			.inc_in (inc_val[c]),
			.pose   (pose_val[c])
		);
	end

	assign out_valid     = out_valid_q;
	assign pose_thumb    = out_pose_q[0];
	assign pose_index    = out_pose_q[1];
	assign pose_middle   = out_pose_q[2];
	assign pose_ring     = out_pose_q[3];
	assign pose_little   = out_pose_q[4];
	assign is_playing    = out_playing_q;
	assign stored_frames = out_count_q;
	assign save_rejected = out_rej_q;

endmodule

// ----- bench/tb_keyframe_linear_interpolator.sv -----
`timescale 1ns / 1ps

module tb_keyframe_linear_interpolator
	import kfli_pkg::*;
();

	localparam logic [1:0] ACT_IGNORED = 2'd3;
	localparam int DIR_ROWS = 25;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 60;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic [1:0]                    action;
		logic [NCH-1:0][ANGLE_W-1:0]   angle;
	} cmd_t;

	typedef struct packed {
		logic [NCH-1:0][POSE_W-1:0]    pose;
		logic                          playing;
		logic [FC_W-1:0]               frames;
		logic                          rejected;
	} pose_report_t;

	typedef struct packed {
		logic                          wr;
		logic [STEPS_W-1:0]            steps;
		cmd_t                          cmd;
		logic                          typed;
		pose_report_t                  want;
	} probe_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [STEPS_W-1:0]  cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          action;
	logic [ANGLE_W-1:0]  thumb_angle;
	logic [ANGLE_W-1:0]  index_angle;
	logic [ANGLE_W-1:0]  middle_angle;
	logic [ANGLE_W-1:0]  ring_angle;
	logic [ANGLE_W-1:0]  little_angle;
	logic                out_valid;
	logic                out_ready;
	logic [POSE_W-1:0]   pose_thumb;
	logic [POSE_W-1:0]   pose_index;
	logic [POSE_W-1:0]   pose_middle;
	logic [POSE_W-1:0]   pose_ring;
	logic [POSE_W-1:0]   pose_little;
	logic                is_playing;
	logic [FC_W-1:0]     stored_frames;
	logic                save_rejected;

	// Player shadow state
	logic [NCH-1:0][ANGLE_W-1:0] kf_table [MAX_KEYFRAMES];
	int                          frames_held;
	bit                          player_on;
	int                          seg;
	int                          step_cnt;
	int                          steps_cur;
	logic [NCH-1:0][POSE_W-1:0]  pose_acc;
	logic [NCH-1:0][POSE_W-1:0]  pose_inc;

	pose_report_t report_q [$];
	pose_report_t got_beat;
	pose_report_t want_beat;
	probe_row_t   dir_tab [DIR_ROWS];

	int mismatches = 0;
	int idle_cycles = 0;
	int send_gap_pct = 0;
	int ready_stall_pct = 0;
	int ready_hold = 0;

	keyframe_linear_interpolator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.thumb_angle   (thumb_angle),
		.index_angle   (index_angle),
		.middle_angle  (middle_angle),
		.ring_angle    (ring_angle),
		.little_angle  (little_angle),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pose_thumb    (pose_thumb),
		.pose_index    (pose_index),
		.pose_middle   (pose_middle),
		.pose_ring     (pose_ring),
		.pose_little   (pose_little),
		.is_playing    (is_playing),
		.stored_frames (stored_frames),
		.save_rejected (save_rejected)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Segment increments: 16.16 difference over steps, truncated toward zero
	function automatic void load_increments();
		int d;
		int q;
		for (int c = 0; c < NCH; c++) begin
			d = $signed(kf_table[seg + 1][c]);
			d = d - $signed(kf_table[seg][c]);
			q = 0;
			if (steps_cur != 0)
				q = (d * 65536) / steps_cur;
			pose_inc[c] = q;
		end
	endfunction

	// Advance the shadow player by one beat and form the result it gives
	function automatic pose_report_t step_player(input cmd_t c);
		pose_report_t r;
		logic [ANGLE_W-1:0] a;
		r.rejected = 1'b0;
		if (c.action == ACT_SAVE) begin
			if (frames_held < MAX_KEYFRAMES) begin
				kf_table[frames_held] = c.angle;
				frames_held++;
			end else begin
				r.rejected = 1'b1;
			end
		end else if (c.action == ACT_PLAY) begin
			if (!player_on && frames_held > 1) begin
				for (int k = 0; k < NCH; k++) begin
					a = kf_table[0][k];
					pose_acc[k] = {{(POSE_W - ANGLE_W - FRAC_W){a[ANGLE_W-1]}}, a, 16'h0000};
				end
				seg = 0;
				step_cnt = 0;
				load_increments();
				player_on = 1'b1;
			end else begin
				player_on = 1'b0;
			end
		end else if (c.action == ACT_TICK && player_on) begin
			if (step_cnt >= steps_cur) begin
				seg++;
				if (seg + 2 > frames_held) begin
					seg = 0;
					player_on = 1'b0;
				end else begin
					step_cnt = 0;
					load_increments();
				end
			end else begin
				for (int k = 0; k < NCH; k++)
					pose_acc[k] = pose_acc[k] + pose_inc[k];
				step_cnt = (step_cnt + 1) & 10'h3FF;
			end
		end
		r.pose = pose_acc;
		r.playing = player_on;
		r.frames = FC_W'(frames_held);
		return r;
	endfunction

	function automatic logic [ANGLE_W-1:0] rand_angle();
		case ($urandom_range(9))
			0: return 10'h200;
			1: return 10'h1FF;
			2: return 10'h000;
			default: return ANGLE_W'($urandom);
		endcase
	endfunction

	function automatic cmd_t rand_cmd(input logic [1:0] act);
		cmd_t c;
		c.action = act;
		for (int k = 0; k < NCH; k++)
			c.angle[k] = rand_angle();
		return c;
	endfunction

	function automatic cmd_t mk_cmd(input logic [1:0] act, input int a0, input int a1,
			input int a2, input int a3, input int a4);
		cmd_t c;
		c.action = act;
		c.angle[0] = ANGLE_W'(a0);
		c.angle[1] = ANGLE_W'(a1);
		c.angle[2] = ANGLE_W'(a2);
		c.angle[3] = ANGLE_W'(a3);
		c.angle[4] = ANGLE_W'(a4);
		return c;
	endfunction

	function automatic pose_report_t flat(input logic [POSE_W-1:0] p, input bit on,
			input int frames);
		pose_report_t r;
		for (int k = 0; k < NCH; k++)
			r.pose[k] = p;
		r.playing = on;
		r.frames = FC_W'(frames);
		r.rejected = 1'b0;
		return r;
	endfunction

	function automatic probe_row_t row(input bit wr, input int steps, input cmd_t c,
			input bit typed, input pose_report_t want);
		probe_row_t r;
		r.wr = wr;
		r.steps = STEPS_W'(steps);
		r.cmd = c;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	// Offer one beat, hold it until accepted, then log the expected result
	task automatic send_beat(input cmd_t c, input bit typed, input pose_report_t want);
		pose_report_t r;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= c.action;
		thumb_angle  <= c.angle[0];
		index_angle  <= c.angle[1];
		middle_angle <= c.angle[2];
		ring_angle   <= c.angle[3];
		little_angle <= c.angle[4];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = step_player(c);
		report_q.push_back(typed ? want : r);
	endtask

	task automatic push_cmd(input cmd_t c);
		send_beat(c, 1'b0, '0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (report_q.size() != 0);
	endtask

	task automatic write_steps(input logic [STEPS_W-1:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		steps_cur = v;
	endtask

	// Mostly save runs and play-then-tick runs, with some noise in between
	task automatic run_bursts(input int n_items);
		int done_items;
		int len;
		int kind;
		done_items = 0;
		while (done_items < n_items) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				len = $urandom_range(1, 12);
				repeat (len) push_cmd(rand_cmd(ACT_SAVE));
			end else if (kind < 85) begin
				len = $urandom_range(1, 30);
				if (player_on)
					push_cmd(rand_cmd(ACT_PLAY));
				push_cmd(rand_cmd(ACT_PLAY));
				repeat (len) push_cmd(rand_cmd(ACT_TICK));
				if ($urandom_range(1))
					push_cmd(rand_cmd(ACT_PLAY));
				len = len + 3;
			end else begin
				len = $urandom_range(1, 4);
				repeat (len) push_cmd(rand_cmd(2'($urandom_range(3))));
			end
			done_items = done_items + len;
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
	endtask

	// Receiver: random stalls, plus an optional long hold-off
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_beat.pose[0]  = pose_thumb;
			got_beat.pose[1]  = pose_index;
			got_beat.pose[2]  = pose_middle;
			got_beat.pose[3]  = pose_ring;
			got_beat.pose[4]  = pose_little;
			got_beat.playing  = is_playing;
			got_beat.frames   = stored_frames;
			got_beat.rejected = save_rejected;
			if (report_q.size() == 0) begin
				flag_mismatch("result beat with nothing expected", 32'd0, 32'd0);
			end else begin
				want_beat = report_q.pop_front();
				for (int k = 0; k < NCH; k++)
					if (got_beat.pose[k] !== want_beat.pose[k])
						flag_mismatch($sformatf("pose channel %0d", k),
							got_beat.pose[k], want_beat.pose[k]);
				if (got_beat.playing !== want_beat.playing)
					flag_mismatch("is_playing", 32'(got_beat.playing),
						32'(want_beat.playing));
				if (got_beat.frames !== want_beat.frames)
					flag_mismatch("stored_frames", 32'(got_beat.frames),
						32'(want_beat.frames));
				if (got_beat.rejected !== want_beat.rejected)
					flag_mismatch("save_rejected", 32'(got_beat.rejected),
						32'(want_beat.rejected));
			end
		end
	end

	// Stop the run if no beat moves on either channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		action       <= '0;
		thumb_angle  <= '0;
		index_angle  <= '0;
		middle_angle <= '0;
		ring_angle   <= '0;
		little_angle <= '0;
		frames_held  = 0;
		player_on    = 1'b0;
		seg          = 0;
		step_cnt     = 0;
		steps_cur    = STEPS_RESET;
		pose_acc     = '0;
		pose_inc     = '0;

		// Directed table: reset state, short tables, extremes, segment edges
		dir_tab[0]  = row(0, 100, mk_cmd(ACT_TICK, 0, 0, 0, 0, 0), 1, flat(0, 0, 0));
		dir_tab[1]  = row(0, 100, mk_cmd(ACT_PLAY, 0, 0, 0, 0, 0), 1, flat(0, 0, 0));
		dir_tab[2]  = row(0, 100, mk_cmd(ACT_IGNORED, -1, -1, -1, -1, -1), 1, flat(0, 0, 0));
		dir_tab[3]  = row(0, 100, mk_cmd(ACT_SAVE, -512, -512, -512, -512, -512), 1,
			flat(0, 0, 1));
		dir_tab[4]  = row(0, 100, mk_cmd(ACT_PLAY, 0, 0, 0, 0, 0), 1, flat(0, 0, 1));
		dir_tab[5]  = row(0, 100, mk_cmd(ACT_SAVE, 511, 511, 511, 511, 511), 1,
			flat(0, 0, 2));
		dir_tab[6]  = row(0, 100, mk_cmd(ACT_SAVE, 0, 1, -1, 255, -256), 1, flat(0, 0, 3));
		dir_tab[7]  = row(0, 100, mk_cmd(ACT_PLAY, 0, 0, 0, 0, 0), 1,
			flat(32'hFE00_0000, 1, 3));
		dir_tab[8]  = row(0, 100, mk_cmd(ACT_TICK, 0, 0, 0, 0, 0), 0, '0);
		dir_tab[9]  = row(0, 100, mk_cmd(ACT_TICK, 0, 0, 0, 0, 0), 0, '0);
		// steps lowered below the step count: the next tick moves on
		dir_tab[10] = row(1, 1, mk_cmd(ACT_TICK, 0, 0, 0, 0, 0), 0, '0);
		dir_tab[11] = row(0, 1, mk_cmd(ACT_TICK, 0, 0, 0, 0, 0), 0, '0);
		dir_tab[12] = row(0, 1, mk_cmd(ACT_TICK, 0, 0, 0, 0, 0), 0, '0);
		dir_tab[13] = row(0, 1, mk_cmd(ACT_TICK, 0, 0, 0, 0, 0), 0, '0);
		dir_tab[14] = row(0, 1, mk_cmd(ACT_PLAY, 0, 0, 0, 0, 0), 0, '0);
		// save while playing extends the animation
		dir_tab[15] = row(0, 1, mk_cmd(ACT_SAVE, -1, -512, 511, 7, 0), 0, '0);
		// zero steps: each tick moves one segment on, and the tick on the last segment stops play
		dir_tab[16] = row(1, 0, mk_cmd(ACT_TICK, 0, 0, 0, 0, 0), 0, '0);
		dir_tab[17] = row(0, 0, mk_cmd(ACT_TICK, 0, 0, 0, 0, 0), 0, '0);
		dir_tab[18] = row(0, 0, mk_cmd(ACT_TICK, 0, 0, 0, 0, 0), 0, '0);
		dir_tab[19] = row(1, 1023, mk_cmd(ACT_PLAY, 0, 0, 0, 0, 0), 0, '0);
		dir_tab[20] = row(0, 1023, mk_cmd(ACT_TICK, 0, 0, 0, 0, 0), 0, '0);
		dir_tab[21] = row(0, 1023, mk_cmd(ACT_PLAY, 0, 0, 0, 0, 0), 0, '0);
		dir_tab[22] = row(1, 3, mk_cmd(ACT_PLAY, 0, 0, 0, 0, 0), 0, '0);
		dir_tab[23] = row(0, 3, mk_cmd(ACT_TICK, 0, 0, 0, 0, 0), 0, '0);
		dir_tab[24] = row(0, 3, mk_cmd(ACT_TICK, 0, 0, 0, 0, 0), 0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int k = 0; k < DIR_ROWS; k++) begin
			if (dir_tab[k].wr)
				write_steps(dir_tab[k].steps);
			send_beat(dir_tab[k].cmd, dir_tab[k].typed, dir_tab[k].want);
		end

		// No idling
		write_steps(2);
		run_bursts(110);

		// Sender gaps, with a pause until all results are back
		send_gap_pct = 48;
		write_steps(1);
		run_bursts(55);
		wait_drained();
		run_bursts(55);

		// Receiver stalls, opening with a long hold-off to back up the input
		send_gap_pct    = 0;
		ready_stall_pct = 48;
		write_steps(1023);
		ready_hold = LONG_HOLD;
		run_bursts(110);

		// Both sides idle
		send_gap_pct    = 17;
		ready_stall_pct = 17;
		write_steps(STEPS_W'($urandom_range(1, 6)));
		run_bursts(110);

		// Fill the table, hit the full case, then play it through end to end
		send_gap_pct    = 0;
		ready_stall_pct = 0;
		while (frames_held < MAX_KEYFRAMES)
			push_cmd(rand_cmd(ACT_SAVE));
		repeat (8) push_cmd(rand_cmd(ACT_SAVE));
		write_steps(0);
		if (player_on)
			push_cmd(rand_cmd(ACT_PLAY));
		push_cmd(rand_cmd(ACT_PLAY));
		while (player_on) begin
			if ($urandom_range(49) == 0)
				push_cmd(rand_cmd(ACT_SAVE));
			push_cmd(rand_cmd(ACT_TICK));
		end

		// Full table with mixed traffic
		send_gap_pct    = 17;
		ready_stall_pct = 17;
		write_steps(5);
		run_bursts(60);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
